// ----- rtl/core/dps_pkg.sv -----
package dps_pkg;

   // Drive states, one-hot
   typedef enum logic [8:0] {
      ST_START    = 9'b000000001,
      ST_NOTREADY = 9'b000000010,
      ST_DISABLED = 9'b000000100,
      ST_READY    = 9'b000001000,
      ST_SWON     = 9'b000010000,
      ST_OPEN     = 9'b000100000,
      ST_QSTOP    = 9'b001000000,
      ST_FREACT   = 9'b010000000,
      ST_FAULT    = 9'b100000000
   } state_type;

   // Pending option actions
   typedef enum logic [2:0] {
      PD_NONE     = 3'd0,
      PD_QSTOP    = 3'd1,
      PD_SHUTDOWN = 3'd2,
      PD_DISOP    = 3'd3,
      PD_FREACT   = 3'd4
   } pend_type;

   // Drive state codes as reported on the result channel
   localparam logic [3:0] DS_START    = 4'd0;
   localparam logic [3:0] DS_NOTREADY = 4'd1;
   localparam logic [3:0] DS_DISABLED = 4'd2;
   localparam logic [3:0] DS_READY    = 4'd3;
   localparam logic [3:0] DS_SWON     = 4'd4;
   localparam logic [3:0] DS_OPEN     = 4'd5;
   localparam logic [3:0] DS_QSTOP    = 4'd6;
   localparam logic [3:0] DS_FREACT   = 4'd7;
   localparam logic [3:0] DS_FAULT    = 4'd8;

   // Configuration register indexes
   localparam logic [2:0] CFG_QUICK_STOP = 3'd0;
   localparam logic [2:0] CFG_SHUTDOWN   = 3'd1;
   localparam logic [2:0] CFG_DISABLE_OP = 3'd2;
   localparam logic [2:0] CFG_FAULT_REACT = 3'd3;
   localparam logic [2:0] CFG_OP_MODE    = 3'd4;

   localparam logic [3:0] OPT_NONE      = 4'd0;
   localparam logic [3:0] MODE_PROFILE  = 4'd1;
   localparam logic [3:0] MODE_VELOCITY = 4'd2;
   localparam logic [3:0] MODE_RESET    = 4'd3;

   // Statusword bits
   localparam logic [15:0] SW_STATE_MASK = 16'h006F;
   localparam logic [15:0] SW_REMOTE     = 16'h0200;
   localparam logic [15:0] SW_TARGET     = 16'h0400;
   localparam int          SW_VOLTAGE_BIT  = 4;
   localparam int          SW_FOLLOWS_BIT  = 12;
   localparam int          SW_MOTOR_EN_BIT = 13;

   localparam logic [15:0] SW_DISABLED = 16'h0040;
   localparam logic [15:0] SW_READY    = 16'h0021;
   localparam logic [15:0] SW_SWON     = 16'h0023;
   localparam logic [15:0] SW_OPEN     = 16'h0027;
   localparam logic [15:0] SW_QSTOP    = 16'h0007;
   localparam logic [15:0] SW_FREACT   = 16'h000F;
   localparam logic [15:0] SW_FAULT    = 16'h0008;

   // Controlword command masks and values
   localparam logic [15:0] CW_M87 = 16'h0087;
   localparam logic [15:0] CW_M86 = 16'h0086;
   localparam logic [15:0] CW_M82 = 16'h0082;
   localparam logic [15:0] CW_M8F = 16'h008F;
   localparam logic [15:0] CW_SHUTDOWN   = 16'h0006;
   localparam logic [15:0] CW_QUICK_STOP = 16'h0002;
   localparam logic [15:0] CW_DISABLE_V  = 16'h0000;
   localparam logic [15:0] CW_SWITCH_ON  = 16'h0007;
   localparam logic [15:0] CW_ENABLE_OP  = 16'h000F;
   localparam logic [15:0] CW_FAULT_RST  = 16'h0080;
   localparam int          CW_FAULT_RST_BIT = 7;
   localparam int          CW_RELATIVE_BIT  = 6;

   typedef struct packed {
      logic [3:0] quick_stop_option;
      logic [3:0] shutdown_option;
      logic [3:0] disable_op_option;
      logic [3:0] fault_reaction_option;
      logic [3:0] operating_mode;
   } cfg_type;

   typedef struct packed {
      logic [15:0] control_word;
      logic        motor_running;
      logic        motor_idle;
      logic        motor_faulted;
      logic        fault_present;
      logic        alignment_done;
      logic        bus_voltage_fault;
   } req_type;

   typedef struct packed {
      logic [15:0] status_word;
      logic [3:0]  drive_state;
      logic [2:0]  pending_action;
      logic        start_motor;
      logic        stop_motor;
      logic        force_motor_idle;
      logic        alarm_clear;
      logic        relative_move;
      logic        brake_applied;
      logic        high_power_on;
      logic        function_enabled;
      logic        config_allowed;
   } rsp_type;

   function automatic logic [3:0] state_code(state_type st);
      logic [3:0] code;
      case (st)
         ST_START:    code = DS_START;
         ST_NOTREADY: code = DS_NOTREADY;
         ST_DISABLED: code = DS_DISABLED;
         ST_READY:    code = DS_READY;
         ST_SWON:     code = DS_SWON;
         ST_OPEN:     code = DS_OPEN;
         ST_QSTOP:    code = DS_QSTOP;
         ST_FREACT:   code = DS_FREACT;
         ST_FAULT:    code = DS_FAULT;
         default:     code = DS_NOTREADY;
      endcase
      return code;
   endfunction

   function automatic logic cmd_is(logic [15:0] cw, logic [15:0] mask, logic [15:0] val);
      return (cw & mask) == val;
   endfunction

   // Option codes whose characteristic completes in one tick
   function automatic logic action_ok(logic [3:0] code);
      return (code >= 4'd1 && code <= 4'd4) || code == 4'd6;
   endfunction

endpackage

// ----- rtl/core/dps_if.sv -----
interface dps_req_if;
   import dps_pkg::*;
   logic        valid;
   logic        ready;
   logic [15:0] control_word;
   logic        motor_running;
   logic        motor_idle;
   logic        motor_faulted;
   logic        fault_present;
   logic        alignment_done;
   logic        bus_voltage_fault;

   modport source (output valid, control_word, motor_running, motor_idle, motor_faulted,
                   fault_present, alignment_done, bus_voltage_fault, input ready);
   modport sink (input valid, control_word, motor_running, motor_idle, motor_faulted,
                 fault_present, alignment_done, bus_voltage_fault, output ready);
endinterface

interface dps_rsp_if;
   import dps_pkg::*;
   logic        valid;
   logic        ready;
   logic [15:0] status_word;
   logic [3:0]  drive_state;
   logic [2:0]  pending_action;
   logic        start_motor;
   logic        stop_motor;
   logic        force_motor_idle;
   logic        alarm_clear;
   logic        relative_move;
   logic        brake_applied;
   logic        high_power_on;
   logic        function_enabled;
   logic        config_allowed;

   modport source (output valid, status_word, drive_state, pending_action, start_motor,
                   stop_motor, force_motor_idle, alarm_clear, relative_move, brake_applied,
                   high_power_on, function_enabled, config_allowed, input ready);
   modport sink (input valid, status_word, drive_state, pending_action, start_motor,
                 stop_motor, force_motor_idle, alarm_clear, relative_move, brake_applied,
                 high_power_on, function_enabled, config_allowed, output ready);
endinterface

// ----- rtl/core/dps_step.sv -----
module dps_step #(
   parameter int STARTUP_TICKS = 10
) (
   input  dps_pkg::cfg_type   cfg,
   input  dps_pkg::req_type   req,
   input  dps_pkg::state_type state_cur,
   input  dps_pkg::pend_type  pend_cur,
   input  logic [$clog2(STARTUP_TICKS+1)-1:0] count_cur,
   input  logic [15:0]        sticky_cur,
   output dps_pkg::state_type state_nxt,
   output dps_pkg::pend_type  pend_nxt,
   output logic [$clog2(STARTUP_TICKS+1)-1:0] count_nxt,
   output logic [15:0]        sticky_nxt,
   output dps_pkg::rsp_type   rsp
);
   import dps_pkg::*;

   localparam int CntW = $clog2(STARTUP_TICKS + 1);

   logic [15:0] s;
   logic [15:0] w;
   logic [15:0] cw;
   state_type   st1;
   logic        early;
   logic        qs_stay;
   logic        start_m;
   logic        fidle;
   logic        aclr;
   logic        rel;
   logic        brake;
   logic        hp;
   logic        fn;
   logic        cfga;

   assign qs_stay = (cfg.quick_stop_option >= 4'd5) && (cfg.quick_stop_option <= 4'd8);

   always_comb begin
      s         = sticky_cur;
      st1       = state_cur;
      pend_nxt  = pend_cur;
      count_nxt = count_cur;
      early     = 1'b0;
      start_m   = 1'b0;
      fidle     = 1'b0;
      aclr      = 1'b0;
      rel       = 1'b0;
      cw        = req.control_word;

      // Resolve the pending action left by the previous request
      if (pend_cur != PD_NONE &&
          (cfg.operating_mode == MODE_PROFILE || cfg.operating_mode == MODE_VELOCITY)) begin
         s[SW_FOLLOWS_BIT] = 1'b0;
      end else begin
         s[SW_FOLLOWS_BIT] = 1'b1;
      end
      case (pend_cur)
         PD_QSTOP: begin
            // Ramp-and-stay codes map onto 1..4, so any code 1..8 completes
            if (cfg.quick_stop_option >= 4'd1 && cfg.quick_stop_option <= 4'd8) begin
               pend_nxt = PD_NONE;
               if (qs_stay) s = s | SW_TARGET;
               else st1 = ST_DISABLED;
            end
         end
         PD_SHUTDOWN: begin
            if (action_ok(cfg.shutdown_option)) begin
               pend_nxt = PD_NONE;
               st1      = ST_READY;
            end
         end
         PD_DISOP: begin
            if (action_ok(cfg.disable_op_option)) begin
               pend_nxt = PD_NONE;
               st1      = ST_SWON;
            end
         end
         PD_FREACT: begin
            if (action_ok(cfg.fault_reaction_option)) begin
               pend_nxt = PD_NONE;
               st1      = ST_FAULT;
            end
         end
         default: ;
      endcase

      // One step of the power state machine
      w                  = s;
      w[SW_MOTOR_EN_BIT] = req.motor_running;
      w                  = w & ~SW_STATE_MASK;
      state_nxt          = st1;
      case (st1)
         ST_START: begin
            if (count_cur >= CntW'(STARTUP_TICKS)) begin
               count_nxt = '0;
               state_nxt = ST_NOTREADY;
            end else begin
               count_nxt = count_cur + CntW'(1);
            end
         end
         ST_NOTREADY: begin
            if (req.alignment_done) state_nxt = ST_DISABLED;
         end
         ST_DISABLED: begin
            w = w | SW_DISABLED;
            if (cmd_is(cw, CW_M87, CW_SHUTDOWN)) state_nxt = ST_READY;
         end
         ST_READY: begin
            w = w | SW_READY;
            if (cmd_is(cw, CW_M86, CW_QUICK_STOP) || cmd_is(cw, CW_M82, CW_DISABLE_V)) begin
               state_nxt = ST_DISABLED;
            end else if (cmd_is(cw, CW_M8F, CW_SWITCH_ON) ||
                         cmd_is(cw, CW_M8F, CW_ENABLE_OP)) begin
               if (!req.bus_voltage_fault) state_nxt = ST_SWON;
            end
         end
         ST_SWON: begin
            w = w | SW_SWON;
            if (cmd_is(cw, CW_M87, CW_SHUTDOWN)) begin
               state_nxt = ST_READY;
            end else if (cmd_is(cw, CW_M86, CW_QUICK_STOP) ||
                         cmd_is(cw, CW_M82, CW_DISABLE_V)) begin
               state_nxt = ST_DISABLED;
            end else if (cmd_is(cw, CW_M8F, CW_ENABLE_OP)) begin
               start_m = req.motor_idle;
               if (req.motor_running) state_nxt = ST_OPEN;
            end
         end
         ST_OPEN: begin
            w = w | SW_OPEN;
            // A motor fault wins over any command
            if (req.motor_faulted) begin
               state_nxt = ST_FREACT;
            end else if (cmd_is(cw, CW_M8F, CW_SWITCH_ON)) begin
               if (cfg.disable_op_option != OPT_NONE) begin
                  pend_nxt = PD_DISOP;
                  early    = 1'b1;
               end else begin
                  state_nxt = ST_SWON;
               end
            end else if (cmd_is(cw, CW_M86, CW_QUICK_STOP)) begin
               state_nxt = ST_QSTOP;
               early     = 1'b1;
            end else if (cmd_is(cw, CW_M87, CW_SHUTDOWN)) begin
               if (cfg.shutdown_option != OPT_NONE) begin
                  pend_nxt = PD_SHUTDOWN;
                  early    = 1'b1;
               end else begin
                  state_nxt = ST_READY;
               end
            end else if (cmd_is(cw, CW_M82, CW_DISABLE_V)) begin
               state_nxt = ST_DISABLED;
            end else begin
               rel = cw[CW_RELATIVE_BIT];
            end
         end
         ST_QSTOP: begin
            w = w | SW_QSTOP;
            if (!req.motor_running || cmd_is(cw, CW_M82, CW_DISABLE_V)) begin
               state_nxt = ST_DISABLED;
               pend_nxt  = PD_NONE;
               early     = 1'b1;
            end else if (cfg.quick_stop_option != OPT_NONE) begin
               pend_nxt = PD_QSTOP;
               early    = 1'b1;
            end else begin
               state_nxt = ST_DISABLED;
            end
         end
         ST_FREACT: begin
            w = w | SW_FREACT;
            if (cfg.fault_reaction_option != OPT_NONE) begin
               pend_nxt = PD_FREACT;
               early    = 1'b1;
            end else begin
               state_nxt = ST_FAULT;
            end
         end
         ST_FAULT: begin
            w = w | SW_FAULT;
            // Automatic reset once no fault remains
            if (!req.fault_present) begin
               fidle = 1'b1;
               cw    = CW_FAULT_RST;
            end
            if (cw[CW_FAULT_RST_BIT]) begin
               aclr      = 1'b1;
               state_nxt = ST_DISABLED;
            end
         end
         default: begin
            w         = '0;
            state_nxt = ST_NOTREADY;
         end
      endcase

      // Flags of the final state
      case (state_nxt)
         ST_SWON: begin
            brake = 1'b1; hp = 1'b1; fn = 1'b0; cfga = 1'b1;
         end
         ST_OPEN, ST_QSTOP, ST_FREACT: begin
            brake = 1'b0; hp = 1'b1; fn = 1'b1; cfga = 1'b0;
         end
         default: begin
            brake = 1'b1; hp = 1'b0; fn = 1'b0; cfga = 1'b1;
         end
      endcase

      // Keep the resolved statusword when the step ends early
      if (!early) begin
         w[SW_VOLTAGE_BIT] = hp;
         w                 = w | SW_REMOTE;
         sticky_nxt        = w;
      end else begin
         sticky_nxt = s;
      end

      rsp.status_word      = sticky_nxt;
      rsp.drive_state      = state_code(state_nxt);
      rsp.pending_action   = pend_nxt;
      rsp.start_motor      = start_m;
      rsp.stop_motor       = !fn && req.alignment_done && req.motor_running;
      rsp.force_motor_idle = fidle;
      rsp.alarm_clear      = aclr;
      rsp.relative_move    = rel;
      rsp.brake_applied    = brake;
      rsp.high_power_on    = hp;
      rsp.function_enabled = fn;
      rsp.config_allowed   = cfga;
   end

endmodule

// ----- rtl/core/dps_rsp_reg.sv -----
module dps_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  dps_pkg::rsp_type data,
   output logic             free,
   dps_rsp_if.source        rsp_bus
);
   import dps_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // Slot is free when empty or being drained this cycle
   assign free     = !valid_ff || rsp_bus.ready;
   assign valid_in = load || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_bus.valid            = valid_ff;
   assign rsp_bus.status_word      = data_ff.status_word;
   assign rsp_bus.drive_state      = data_ff.drive_state;
   assign rsp_bus.pending_action   = data_ff.pending_action;
   assign rsp_bus.start_motor      = data_ff.start_motor;
   assign rsp_bus.stop_motor       = data_ff.stop_motor;
   assign rsp_bus.force_motor_idle = data_ff.force_motor_idle;
   assign rsp_bus.alarm_clear      = data_ff.alarm_clear;
   assign rsp_bus.relative_move    = data_ff.relative_move;
   assign rsp_bus.brake_applied    = data_ff.brake_applied;
   assign rsp_bus.high_power_on    = data_ff.high_power_on;
   assign rsp_bus.function_enabled = data_ff.function_enabled;
   assign rsp_bus.config_allowed   = data_ff.config_allowed;

endmodule

// ----- rtl/core/drive_power_state_machine.sv -----
// A request waits in the request register until the response slot is free; its response is
// then registered. Throughput: one request per cycle unless responses stall; the drive state,
// pending action, start-up count and statusword commit with it for the next request to see.
// Reset (synchronous, active high) returns the axis to the start state with no pending
// action, a zero start-up count and statusword, and the option registers at their defaults.
module drive_power_state_machine #(
   parameter int STARTUP_TICKS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [3:0]  csr_wdata,
   dps_req_if.sink     req_bus,
   dps_rsp_if.source   rsp_bus
);
   import dps_pkg::*;

   localparam int CntW = $clog2(STARTUP_TICKS + 1);

   cfg_type            cfg_ff;
   req_type            req_ff;
   logic               req_valid_ff;
   logic               req_valid_in;
   state_type          state_ff;
   state_type          state_in;
   pend_type           pend_ff;
   pend_type           pend_in;
   logic [CntW-1:0]    count_ff;
   logic [CntW-1:0]    count_in;
   logic [15:0]        sticky_ff;
   logic [15:0]        sticky_in;
   rsp_type            rsp_data;
   logic               rsp_free;
   logic               advance;
   logic               req_take;

   // Advance when a request is held and the response slot can take it
   assign advance      = req_valid_ff && rsp_free;
   assign req_bus.ready = !req_valid_ff || advance;
   assign req_take     = req_bus.valid && req_bus.ready;
   assign req_valid_in = req_take || (req_valid_ff && !advance);

   // Hold the option registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quick_stop_option     <= OPT_NONE;
         cfg_ff.shutdown_option       <= OPT_NONE;
         cfg_ff.disable_op_option     <= OPT_NONE;
         cfg_ff.fault_reaction_option <= OPT_NONE;
         cfg_ff.operating_mode        <= MODE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CFG_QUICK_STOP:  cfg_ff.quick_stop_option     <= csr_wdata;
            CFG_SHUTDOWN:    cfg_ff.shutdown_option       <= csr_wdata;
            CFG_DISABLE_OP:  cfg_ff.disable_op_option     <= csr_wdata;
            CFG_FAULT_REACT: cfg_ff.fault_reaction_option <= csr_wdata;
            CFG_OP_MODE:     cfg_ff.operating_mode        <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.control_word      <= req_bus.control_word;
         req_ff.motor_running     <= req_bus.motor_running;
         req_ff.motor_idle        <= req_bus.motor_idle;
         req_ff.motor_faulted     <= req_bus.motor_faulted;
         req_ff.fault_present     <= req_bus.fault_present;
         req_ff.alignment_done    <= req_bus.alignment_done;
         req_ff.bus_voltage_fault <= req_bus.bus_voltage_fault;
      end
   end

   dps_step #(
      .STARTUP_TICKS (STARTUP_TICKS)
   ) u_step (
      .cfg        (cfg_ff),
      .req        (req_ff),
      .state_cur  (state_ff),
      .pend_cur   (pend_ff),
      .count_cur  (count_ff),
      .sticky_cur (sticky_ff),
      .state_nxt  (state_in),
      .pend_nxt   (pend_in),
      .count_nxt  (count_in),
      .sticky_nxt (sticky_in),
      .rsp        (rsp_data)
   );

   // Commit the axis state on each advanced request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_START;
         pend_ff   <= PD_NONE;
         count_ff  <= '0;
         sticky_ff <= '0;
      end else if (advance) begin
         state_ff  <= state_in;
         pend_ff   <= pend_in;
         count_ff  <= count_in;
         sticky_ff <= sticky_in;
      end
   end

   dps_rsp_reg u_rsp_reg (
      .clock   (clock),
      .reset   (reset),
      .load    (advance),
      .data    (rsp_data),
      .free    (rsp_free),
      .rsp_bus (rsp_bus)
   );

   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_bus.valid)
      else $error("advanced request produced no response");

   a_count_only_in_start: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> state_ff == ST_START)
      else $error("start-up count running outside start state");

   a_state_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff) && $stable(pend_ff) && $stable(sticky_ff))
      else $error("axis state moved without a request");

   a_alarm_clear_to_disabled: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.alarm_clear || rsp_bus.force_motor_idle) |->
         rsp_bus.drive_state == DS_DISABLED && rsp_bus.alarm_clear)
      else $error("fault reset response not in switch-on disabled");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

import dps_pkg::*;

// Tracks the drive power state of one axis and holds the responses it predicts
class drive_scoreboard;
   cfg_type      cfg;
   logic [3:0]   drive_now;
   pend_type     pend_now;
   logic [3:0]   boot_count;
   logic [15:0]  held_status;
   int           boot_limit;
   rsp_type      expected_q[$];
   int unsigned  error_count;

   function new(int ticks);
      boot_limit  = ticks;
      error_count = 0;
      cfg = '0;
      cfg.operating_mode = MODE_RESET;
      drive_now   = DS_START;
      pend_now    = PD_NONE;
      boot_count  = '0;
      held_status = '0;
   endfunction

   function void apply_config(logic [2:0] idx, logic [3:0] val);
      case (idx)
         CFG_QUICK_STOP:  cfg.quick_stop_option = val;
         CFG_SHUTDOWN:    cfg.shutdown_option = val;
         CFG_DISABLE_OP:  cfg.disable_op_option = val;
         CFG_FAULT_REACT: cfg.fault_reaction_option = val;
         CFG_OP_MODE:     cfg.operating_mode = val;
         default: ;
      endcase
   endfunction

   function bit masked_eq(logic [15:0] cw, logic [15:0] mask, logic [15:0] val);
      return (cw & mask) == val;
   endfunction

   // Option codes whose characteristic finishes within one tick
   function bit option_completes(logic [3:0] code);
      return (code >= 4'd1 && code <= 4'd4) || code == 4'd6;
   endfunction

   // Advance the axis by one control tick and return the response it gives
   function rsp_type advance_tick(req_type r);
      rsp_type     o;
      logic [15:0] cw;
      logic [15:0] s;
      logic [15:0] w;
      logic [3:0]  ramp;
      logic [3:0]  qs;
      bit          early;
      qs = cfg.quick_stop_option;
      o = '0;
      early = 0;
      cw = r.control_word;

      // resolve the action left pending by the previous tick
      s = held_status;
      s[SW_FOLLOWS_BIT] = !(pend_now != PD_NONE &&
                            (cfg.operating_mode == MODE_PROFILE ||
                             cfg.operating_mode == MODE_VELOCITY));
      case (pend_now)
         PD_QSTOP: begin
            ramp = (qs >= 4'd5 && qs <= 4'd8) ? qs - 4'd4 : qs;
            if (option_completes(ramp)) begin
               pend_now = PD_NONE;
               if (qs >= 4'd1 && qs <= 4'd4)
                  drive_now = DS_DISABLED;
               else if (qs >= 4'd5 && qs <= 4'd8)
                  s = s | SW_TARGET;
            end
         end
         PD_SHUTDOWN: begin
            if (option_completes(cfg.shutdown_option)) begin
               pend_now = PD_NONE;
               drive_now = DS_READY;
            end
         end
         PD_DISOP: begin
            if (option_completes(cfg.disable_op_option)) begin
               pend_now = PD_NONE;
               drive_now = DS_SWON;
            end
         end
         PD_FREACT: begin
            if (option_completes(cfg.fault_reaction_option)) begin
               pend_now = PD_NONE;
               drive_now = DS_FAULT;
            end
         end
         default: ;
      endcase
      held_status = s;

      // one step of the state machine
      w = s;
      w[SW_MOTOR_EN_BIT] = r.motor_running;
      w = w & ~SW_STATE_MASK;
      case (drive_now)
         DS_START: begin
            if (boot_count >= 4'(boot_limit)) begin
               boot_count = '0;
               drive_now = DS_NOTREADY;
            end else begin
               boot_count = boot_count + 4'd1;
            end
         end
         DS_NOTREADY: begin
            if (r.alignment_done) drive_now = DS_DISABLED;
         end
         DS_DISABLED: begin
            w = w | SW_DISABLED;
            if (masked_eq(cw, CW_M87, CW_SHUTDOWN)) drive_now = DS_READY;
         end
         DS_READY: begin
            w = w | SW_READY;
            if (masked_eq(cw, CW_M86, CW_QUICK_STOP) || masked_eq(cw, CW_M82, CW_DISABLE_V))
               drive_now = DS_DISABLED;
            else if (masked_eq(cw, CW_M8F, CW_SWITCH_ON) || masked_eq(cw, CW_M8F, CW_ENABLE_OP)) begin
               if (!r.bus_voltage_fault) drive_now = DS_SWON;
            end
         end
         DS_SWON: begin
            w = w | SW_SWON;
            if (masked_eq(cw, CW_M87, CW_SHUTDOWN))
               drive_now = DS_READY;
            else if (masked_eq(cw, CW_M86, CW_QUICK_STOP) || masked_eq(cw, CW_M82, CW_DISABLE_V))
               drive_now = DS_DISABLED;
            else if (masked_eq(cw, CW_M8F, CW_ENABLE_OP)) begin
               if (r.motor_idle) o.start_motor = 1'b1;
               if (r.motor_running) drive_now = DS_OPEN;
            end
         end
         DS_OPEN: begin
            w = w | SW_OPEN;
            // a motor fault wins over any command
            if (r.motor_faulted)
               drive_now = DS_FREACT;
            else if (masked_eq(cw, CW_M8F, CW_SWITCH_ON)) begin
               if (cfg.disable_op_option != OPT_NONE) begin
                  pend_now = PD_DISOP;
                  early = 1;
               end else drive_now = DS_SWON;
            end else if (masked_eq(cw, CW_M86, CW_QUICK_STOP)) begin
               drive_now = DS_QSTOP;
               early = 1;
            end else if (masked_eq(cw, CW_M87, CW_SHUTDOWN)) begin
               if (cfg.shutdown_option != OPT_NONE) begin
                  pend_now = PD_SHUTDOWN;
                  early = 1;
               end else drive_now = DS_READY;
            end else if (masked_eq(cw, CW_M82, CW_DISABLE_V))
               drive_now = DS_DISABLED;
            else if (cw[CW_RELATIVE_BIT])
               o.relative_move = 1'b1;
         end
         DS_QSTOP: begin
            w = w | SW_QSTOP;
            if (!r.motor_running || masked_eq(cw, CW_M82, CW_DISABLE_V)) begin
               drive_now = DS_DISABLED;
               pend_now = PD_NONE;
               early = 1;
            end else if (qs != OPT_NONE) begin
               pend_now = PD_QSTOP;
               early = 1;
            end else drive_now = DS_DISABLED;
         end
         DS_FREACT: begin
            w = w | SW_FREACT;
            if (cfg.fault_reaction_option != OPT_NONE) begin
               pend_now = PD_FREACT;
               early = 1;
            end else drive_now = DS_FAULT;
         end
         DS_FAULT: begin
            w = w | SW_FAULT;
            // no fault left: reset on its own
            if (!r.fault_present) begin
               o.force_motor_idle = 1'b1;
               cw = CW_FAULT_RST;
            end
            if (cw[CW_FAULT_RST_BIT]) begin
               o.alarm_clear = 1'b1;
               drive_now = DS_DISABLED;
            end
         end
         default: begin
            w = '0;
            drive_now = DS_NOTREADY;
         end
      endcase

      // flags follow the final state
      case (drive_now)
         DS_SWON: begin
            o.brake_applied = 1'b1;
            o.high_power_on = 1'b1;
            o.config_allowed = 1'b1;
         end
         DS_OPEN, DS_QSTOP, DS_FREACT: begin
            o.high_power_on = 1'b1;
            o.function_enabled = 1'b1;
         end
         default: begin
            o.brake_applied = 1'b1;
            o.config_allowed = 1'b1;
         end
      endcase
      if (!early) begin
         w[SW_VOLTAGE_BIT] = o.high_power_on;
         w = w | SW_REMOTE;
         held_status = w;
      end
      o.stop_motor = drive_now != DS_OPEN && drive_now != DS_QSTOP && drive_now != DS_FREACT &&
                     r.alignment_done && r.motor_running;
      o.status_word = held_status;
      o.drive_state = drive_now;
      o.pending_action = pend_now;
      return o;
   endfunction

   function void note_request(req_type r);
      expected_q.push_back(advance_tick(r));
   endfunction

   task report_mismatch(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task compare_field(string field, int unsigned got, int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", field, got, want));
   endtask

   task check_response(rsp_type got);
      rsp_type want;
      if (expected_q.size() == 0) begin
         report_mismatch("response arrived with no request outstanding");
         return;
      end
      want = expected_q.pop_front();
      compare_field("status_word", got.status_word, want.status_word);
      compare_field("drive_state", got.drive_state, want.drive_state);
      compare_field("pending_action", got.pending_action, want.pending_action);
      compare_field("start_motor", got.start_motor, want.start_motor);
      compare_field("stop_motor", got.stop_motor, want.stop_motor);
      compare_field("force_motor_idle", got.force_motor_idle, want.force_motor_idle);
      compare_field("alarm_clear", got.alarm_clear, want.alarm_clear);
      compare_field("relative_move", got.relative_move, want.relative_move);
      compare_field("brake_applied", got.brake_applied, want.brake_applied);
      compare_field("high_power_on", got.high_power_on, want.high_power_on);
      compare_field("function_enabled", got.function_enabled, want.function_enabled);
      compare_field("config_allowed", got.config_allowed, want.config_allowed);
   endtask
endclass

module tb;
   localparam int BOOT_TICKS = 10;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 116;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic [2:0] csr_index = CFG_QUICK_STOP;
   logic [3:0] csr_wdata = OPT_NONE;
   bit         steady = 0;

   drive_scoreboard scb;

   dps_req_if req_bus ();
   dps_rsp_if rsp_bus ();

   drive_power_state_machine #(.STARTUP_TICKS(BOOT_TICKS)) uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   always #6 clock = ~clock;

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Controlword with the command bits fixed and the rest random
   function automatic logic [15:0] command(logic [15:0] val);
      return (16'($urandom) & ~CW_M8F) | val;
   endfunction

   function automatic req_type tick(logic [15:0] cw, bit run, bit idle, bit flt, bit fpres,
                                    bit align, bit busf);
      req_type r;
      r.control_word = cw;
      r.motor_running = run;
      r.motor_idle = idle;
      r.motor_faulted = flt;
      r.fault_present = fpres;
      r.alignment_done = align;
      r.bus_voltage_fault = busf;
      return r;
   endfunction

   // Pick a request that mostly moves the axis along the usual path
   function automatic req_type make_request(logic [3:0] st);
      req_type r;
      int      roll;
      r = tick(16'($urandom), $urandom_range(0, 99) < 70, 1'($urandom_range(0, 1)),
               $urandom_range(0, 99) < 8, 1'($urandom_range(0, 1)),
               $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 10);
      if ($urandom_range(0, 99) < 15) return r;
      roll = $urandom_range(0, 99);
      case (st)
         DS_DISABLED: begin
            if (roll < 75) r.control_word = command(CW_SHUTDOWN);
         end
         DS_READY: begin
            if (roll < 40) r.control_word = command(CW_SWITCH_ON);
            else if (roll < 65) r.control_word = command(CW_ENABLE_OP);
            else if (roll < 80) r.control_word = command(CW_SHUTDOWN);
         end
         DS_SWON: begin
            r.motor_idle = $urandom_range(0, 99) < 60;
            if (roll < 55) begin
               r.control_word = command(CW_ENABLE_OP);
               r.motor_running = $urandom_range(0, 99) < 85;
            end else if (roll < 65) r.control_word = command(CW_SHUTDOWN);
            else if (roll < 72) r.control_word = command(CW_QUICK_STOP);
         end
         DS_OPEN: begin
            r.motor_faulted = $urandom_range(0, 99) < 6;
            r.motor_running = $urandom_range(0, 99) < 80;
            if (roll < 30) r.control_word = command(CW_ENABLE_OP);
            else if (roll < 45) r.control_word = command(CW_SWITCH_ON);
            else if (roll < 60) r.control_word = command(CW_QUICK_STOP);
            else if (roll < 75) r.control_word = command(CW_SHUTDOWN);
            else if (roll < 83) r.control_word = command(CW_DISABLE_V);
         end
         DS_QSTOP: begin
            r.motor_running = $urandom_range(0, 99) < 75;
            if (roll < 15) r.control_word = command(CW_DISABLE_V);
            else if (roll < 60) r.control_word = command(CW_QUICK_STOP);
         end
         DS_FREACT, DS_FAULT: begin
            r.fault_present = $urandom_range(0, 99) < 60;
            if (roll < 70) r.control_word = r.control_word & ~CW_FAULT_RST;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Present one request, hold it until accepted, then idle for a random gap (none when steady)
   task automatic issue(req_type r);
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.control_word <= r.control_word;
      req_bus.motor_running <= r.motor_running;
      req_bus.motor_idle <= r.motor_idle;
      req_bus.motor_faulted <= r.motor_faulted;
      req_bus.fault_present <= r.fault_present;
      req_bus.alignment_done <= r.alignment_done;
      req_bus.bus_voltage_fault <= r.bus_voltage_fault;
      do @(posedge clock); while (!req_bus.ready);
      scb.note_request(r);
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait for every outstanding response
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (scb.expected_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [3:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      scb.apply_config(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_options(logic [3:0] qs, logic [3:0] sd, logic [3:0] dop,
                              logic [3:0] fr, logic [3:0] mode);
      write_csr(CFG_QUICK_STOP, qs);
      write_csr(CFG_SHUTDOWN, sd);
      write_csr(CFG_DISABLE_OP, dop);
      write_csr(CFG_FAULT_REACT, fr);
      write_csr(CFG_OP_MODE, mode);
   endtask

   function automatic logic [3:0] random_option();
      if ($urandom_range(0, 3) == 0) return OPT_NONE;
      return 4'($urandom_range(1, 8));
   endfunction

   // Response side: check each accepted response, stall at random unless steady
   initial begin
      rsp_type got;
      int      hold;
      hold = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.status_word = rsp_bus.status_word;
            got.drive_state = rsp_bus.drive_state;
            got.pending_action = rsp_bus.pending_action;
            got.start_motor = rsp_bus.start_motor;
            got.stop_motor = rsp_bus.stop_motor;
            got.force_motor_idle = rsp_bus.force_motor_idle;
            got.alarm_clear = rsp_bus.alarm_clear;
            got.relative_move = rsp_bus.relative_move;
            got.brake_applied = rsp_bus.brake_applied;
            got.high_power_on = rsp_bus.high_power_on;
            got.function_enabled = rsp_bus.function_enabled;
            got.config_allowed = rsp_bus.config_allowed;
            scb.check_response(got);
         end
         if (steady) begin
            rsp_bus.ready <= 1'b1;
            hold = 0;
         end else if (hold > 0) begin
            hold--;
         end else begin
            hold = pick_gap();
            if (hold == 0) begin
               rsp_bus.ready <= 1'b1;
               hold = $urandom_range(0, 10);
            end else begin
               rsp_bus.ready <= 1'b0;
               hold--;
            end
         end
      end
   end

   // Stimulus
   initial begin
      scb = new(BOOT_TICKS);
      req_bus.valid <= 1'b0;
      req_bus.control_word <= '0;
      req_bus.motor_running <= 1'b0;
      req_bus.motor_idle <= 1'b0;
      req_bus.motor_faulted <= 1'b0;
      req_bus.fault_present <= 1'b0;
      req_bus.alignment_done <= 1'b0;
      req_bus.bus_voltage_fault <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // start delay with extreme fields, then walk to operation enabled and through a fault
      issue(tick(16'hFFFF, 1, 1, 1, 1, 1, 1));
      issue(tick(16'h0000, 0, 0, 0, 0, 0, 0));
      repeat (BOOT_TICKS - 1) issue(make_request(scb.drive_now));
      issue(tick(16'hFFFF, 1, 0, 0, 1, 0, 0));
      issue(tick(16'h0000, 0, 1, 0, 0, 1, 0));
      issue(tick(CW_DISABLE_V, 0, 0, 0, 0, 1, 0));
      issue(tick(CW_SHUTDOWN, 0, 0, 0, 0, 1, 0));
      issue(tick(CW_SWITCH_ON, 0, 0, 0, 0, 1, 1));
      issue(tick(CW_SWITCH_ON, 0, 0, 0, 0, 1, 0));
      issue(tick(CW_ENABLE_OP, 0, 1, 0, 0, 1, 0));
      issue(tick(CW_ENABLE_OP, 1, 0, 0, 0, 1, 0));
      issue(tick(CW_ENABLE_OP | 16'h0040, 1, 0, 0, 0, 1, 0));
      issue(tick(CW_ENABLE_OP, 1, 0, 1, 1, 1, 0));
      issue(tick(CW_DISABLE_V, 1, 0, 1, 1, 1, 0));
      issue(tick(CW_DISABLE_V, 0, 0, 0, 1, 1, 0));
      issue(tick(CW_DISABLE_V, 0, 0, 0, 0, 1, 0));

      // random phases, each under its own option setting
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         steady = (ph == 2);
         case (ph)
            0: ;
            1: set_options(OPT_NONE, OPT_NONE, OPT_NONE, OPT_NONE, 4'd0);
            2: set_options(4'd8, 4'd8, 4'd8, 4'd8, 4'd10);
            3: set_options(random_option(), random_option(), random_option(),
                           random_option(), MODE_PROFILE);
            4: set_options(random_option(), random_option(), random_option(),
                           random_option(), MODE_VELOCITY);
            default: set_options(random_option(), random_option(), random_option(),
                                 random_option(), 4'($urandom_range(0, 10)));
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off until the response side has caught up
            if (n == PHASE_ITEMS / 2 && ph < 2) wait_drained();
            issue(make_request(scb.drive_now));
         end
      end
      steady = 0;
      wait_drained();
      repeat (4) @(posedge clock);
      if (scb.expected_q.size() != 0)
         scb.report_mismatch($sformatf("%0d responses never arrived", scb.expected_q.size()));
      if (scb.error_count == 0) begin
         $display("PASS drive_power_state_machine");
      end else begin
         $display("FAIL drive_power_state_machine");
      end
      $finish;
   end

   // Give up if the run hangs
   initial begin
      #10_000_000;
      $display("FAIL drive_power_state_machine");
      $finish;
   end
endmodule
